### hw/rtl/pplh_pkg.sv
// ----------------------------------------------------------------------------
// pplh_pkg
// Shared types and constants for the peak pair landmark hasher.
// ----------------------------------------------------------------------------
package pplh_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH       = 2;

  localparam int FREQ_W  = 15;
  localparam int MAG_W   = 17;
  localparam int AMP_W   = 10;
  localparam int TIME_W  = 40;
  localparam int MTD_W   = 24;
  localparam int HASH_W  = 32;
  localparam int HFREQ_W = 13;
  localparam int DTMS_W  = 6;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (HASH_W + TIME_W + FREQ_W + AMP_W);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = MTD_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_FREQ_DELTA    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FREQ_DELTA    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TIME_DELTA_US = 2'd2;

  localparam logic [FREQ_W-1:0] MIN_FREQ_DELTA_RST    = 15'd0;
  localparam logic [FREQ_W-1:0] MAX_FREQ_DELTA_RST    = 15'd32767;
  localparam logic [MTD_W-1:0]  MAX_TIME_DELTA_US_RST = 24'd1000000;

  localparam logic [MAG_W-1:0]  MAG_ONE     = 17'h10000;
  localparam logic [AMP_W-1:0]  AMP_SCALE   = 10'd1000;
  localparam logic [TIME_W-1:0] MIN_AGE_US  = 40'd1000;

  // floor(x / 1000) = ((x >> 3) * DIV_MAGIC) >> DIV_SHIFT, exact for x < 2^24
  localparam logic [21:0] DIV_MAGIC = 22'd2147484;
  localparam int          DIV_SHIFT = 28;

  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [AMP_W-1:0]  amp;
    logic [FREQ_W-1:0] freq;
  } hist_entry_t;

  typedef struct packed {
    logic        clear;
    hist_entry_t peak;
  } cmd_t;

  typedef struct packed {
    logic [FREQ_W-1:0] min_freq_delta;
    logic [FREQ_W-1:0] max_freq_delta;
    logic [MTD_W-1:0]  max_time_delta_us;
  } cfg_t;

  typedef struct packed {
    logic [AMP_W-1:0]  anchor_amplitude;
    logic [FREQ_W-1:0] anchor_frequency;
    logic [TIME_W-1:0] anchor_time_us;
    logic [HASH_W-1:0] pair_hash;
  } res_t;

endpackage

### hw/rtl/pplh_front.sv
// ----------------------------------------------------------------------------
// pplh_front
// Input stage: takes peaks and clear actions, scales the magnitude to an
// amplitude and hands one command at a time to the queue.
// ----------------------------------------------------------------------------
module pplh_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [14:0] peak_frequency, [31:15] peak_magnitude, [71:32] peak_time_us
  input  logic [pplh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] action
  input  logic [0:0]                        s_axis_tuser,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output pplh_pkg::cmd_t                    cmd
);
  import pplh_pkg::*;

  logic [MAG_W-1:0]         mag_in;
  logic [MAG_W-1:0]         mag_sat;
  logic [MAG_W+AMP_W-1:0]   amp_prod;

  assign mag_in   = s_axis_tdata[FREQ_W +: MAG_W];
  assign mag_sat  = mag_in[MAG_W-1] ? MAG_ONE : mag_in;
  assign amp_prod = (MAG_W+AMP_W)'(mag_sat) * (MAG_W+AMP_W)'(AMP_SCALE);

  assign s_axis_tready = ~cmd_valid | cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_axis_tready) begin
      cmd_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd.clear       <= s_axis_tuser[0];
      cmd.peak.freq   <= s_axis_tdata[FREQ_W-1:0];
      cmd.peak.amp    <= amp_prod[16 +: AMP_W];
      cmd.peak.tstamp <= s_axis_tdata[FREQ_W+MAG_W +: TIME_W];
    end
  end

endmodule

### hw/rtl/pplh_queue.sv
// ----------------------------------------------------------------------------
// pplh_queue
// Short command queue between the input stage and the history walker.
// ----------------------------------------------------------------------------
module pplh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pplh_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output pplh_pkg::cmd_t out_cmd
);
  import pplh_pkg::*;

  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QIDX_W-1:0] Q_LAST = QIDX_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] Q_FULL = QCNT_W'(QUEUE_DEPTH);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wp;
  logic [QIDX_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;
  logic              push;
  logic              pop;

  assign in_ready  = (cnt != Q_FULL);
  assign out_valid = (cnt != '0);
  assign out_cmd   = slots[rp];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == Q_LAST) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == Q_LAST) ? '0 : rp + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= in_cmd;
    end
  end

endmodule

### hw/rtl/pplh_back.sv
// ----------------------------------------------------------------------------
// pplh_back
// History walker: reads the peak ring oldest first via a three-stage compare
// pipeline, emits a transaction per pair or one no-pair, then stores the peak.
// ----------------------------------------------------------------------------
module pplh_back #(
  parameter int HISTORY_DEPTH = pplh_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pplh_pkg::cfg_t                     cfg,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  pplh_pkg::cmd_t                     cmd,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] pair_hash, [71:32] anchor_time_us, [86:72] anchor_frequency,
  // [96:87] anchor_amplitude, [103:97] zero
  output logic [pplh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] pair_valid
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);
  import pplh_pkg::*;

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_X   = (CNT_W+1)'(HISTORY_DEPTH);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t            state;
  hist_entry_t       hist_mem [HISTORY_DEPTH];
  logic [CNT_W-1:0]  hist_count;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  issue_left;
  cmd_t              cur;

  logic              s1v, s2v, s3v;
  hist_entry_t       rd_entry;
  logic [TIME_W:0]   s2_dt;
  logic [FREQ_W-1:0] s2_fd;
  hist_entry_t       s2_entry;
  logic              s3_match;
  res_t              s3_res;
  logic              hv;
  res_t              held;
  res_t              out_res;
  logic              out_pair;
  logic              out_last;

  logic [CNT_W:0]    start_sum;
  logic [PTR_W-1:0]  start_slot;
  logic [PTR_W-1:0]  rd_ptr_inc;
  logic [PTR_W-1:0]  wr_ptr_inc;
  logic              freq_ge;
  logic [FREQ_W-1:0] fd_abs;
  logic              pair_ok;
  logic [42:0]       dt_prod;
  logic              out_free;
  logic              adv;
  logic              walk_empty;
  logic              step;
  logic              push_pair;
  logic              finish;

  assign start_sum  = (CNT_W+1)'(wr_ptr) + DEPTH_X - (CNT_W+1)'(hist_count);
  assign start_slot = (start_sum >= DEPTH_X) ? PTR_W'(start_sum - DEPTH_X)
                                             : PTR_W'(start_sum);
  assign rd_ptr_inc = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_inc = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;

  assign freq_ge = (cur.peak.freq >= rd_entry.freq);
  assign fd_abs  = freq_ge ? cur.peak.freq - rd_entry.freq
                           : rd_entry.freq - cur.peak.freq;

  assign pair_ok = ~s2_dt[TIME_W]
                 & (s2_dt[TIME_W-1:0] >= MIN_AGE_US)
                 & (s2_dt[TIME_W-1:0] <= TIME_W'(cfg.max_time_delta_us))
                 & (s2_fd >= cfg.min_freq_delta)
                 & (s2_fd <= cfg.max_freq_delta);
  assign dt_prod = 43'(s2_dt[23:3]) * 43'(DIV_MAGIC);

  assign out_free   = ~m_axis_tvalid | m_axis_tready;
  assign adv        = ~(s3v & s3_match & hv & ~out_free);
  assign walk_empty = (issue_left == '0) & ~s1v & ~s2v & ~s3v;
  assign step       = (state == ST_WALK) & ~walk_empty & adv;
  assign push_pair  = step & s3v & s3_match & hv;
  assign finish     = (state == ST_WALK) & walk_empty & out_free;

  assign cmd_ready = (state == ST_IDLE);

  assign m_axis_tdata = {OUT_PAD_W'(0), out_res};
  assign m_axis_tuser = out_pair;
  assign m_axis_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hist_count    <= '0;
      wr_ptr        <= '0;
      issue_left    <= '0;
      s1v           <= 1'b0;
      s2v           <= 1'b0;
      s3v           <= 1'b0;
      hv            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push_pair || finish) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (step) begin
        s1v <= (issue_left != '0);
        s2v <= s1v;
        s3v <= s2v;
        if (issue_left != '0) begin
          issue_left <= issue_left - 1'b1;
        end
        if (s3v && s3_match) begin
          hv <= 1'b1;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.clear) begin
              hist_count <= '0;
              wr_ptr     <= '0;
            end else begin
              issue_left <= hist_count;
              hv         <= 1'b0;
              state      <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (finish) begin
            wr_ptr <= wr_ptr_inc;
            if (hist_count != FULL_CNT) begin
              hist_count <= hist_count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      cur    <= cmd;
      rd_ptr <= start_slot;
    end else if (step && issue_left != '0) begin
      rd_ptr <= rd_ptr_inc;
    end
    if (step) begin
      if (issue_left != '0) begin
        rd_entry <= hist_mem[rd_ptr];
      end
      s2_dt    <= {1'b0, cur.peak.tstamp} - {1'b0, rd_entry.tstamp};
      s2_fd    <= fd_abs;
      s2_entry <= rd_entry;
      s3_match <= pair_ok;
      s3_res.pair_hash        <= {s2_entry.freq[HFREQ_W-1:0], cur.peak.freq[HFREQ_W-1:0],
                                  dt_prod[DIV_SHIFT +: DTMS_W]};
      s3_res.anchor_time_us   <= s2_entry.tstamp;
      s3_res.anchor_frequency <= s2_entry.freq;
      s3_res.anchor_amplitude <= s2_entry.amp;
      if (s3v && s3_match) begin
        held <= s3_res;
      end
    end
    if (finish) begin
      hist_mem[wr_ptr] <= cur.peak;
    end
    if (push_pair) begin
      out_res  <= held;
      out_pair <= 1'b1;
      out_last <= 1'b0;
    end else if (finish) begin
      out_res  <= hv ? held : '0;
      out_pair <= hv;
      out_last <= 1'b1;
    end
  end

endmodule

### hw/rtl/peak_pair_landmark_hasher.sv
// ----------------------------------------------------------------------------
// peak_pair_landmark_hasher
// Pairs each incoming spectral peak with recent stored peaks and emits a
// landmark hash transaction per pair, or one no-pair transaction.
// Each peak is walked against every stored peak, oldest first; each pair is
// held until the walk finds the next pair or ends. The single-read-port
// history walk reads one stored peak per cycle while the output is not
// stalled, and the walker takes a new peak only once its last walk is done.
// A clear passes the input register and the queue before it empties the
// history. Output stalls pause the walk. Reset (rst, synchronous) empties the
// history and restores the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module peak_pair_landmark_hasher #(
  parameter int HISTORY_DEPTH = pplh_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [14:0] peak_frequency, [31:15] peak_magnitude, [71:32] peak_time_us
  input  logic [pplh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] action
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] pair_hash, [71:32] anchor_time_us, [86:72] anchor_frequency,
  // [96:87] anchor_amplitude, [103:97] zero
  output logic [pplh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] pair_valid
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we,
  input  logic [pplh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pplh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pplh_pkg::*;

  cfg_t cfg;
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_freq_delta    <= MIN_FREQ_DELTA_RST;
      cfg.max_freq_delta    <= MAX_FREQ_DELTA_RST;
      cfg.max_time_delta_us <= MAX_TIME_DELTA_US_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MIN_FREQ_DELTA:    cfg.min_freq_delta    <= cfg_wdata[FREQ_W-1:0];
        CFG_MAX_FREQ_DELTA:    cfg.max_freq_delta    <= cfg_wdata[FREQ_W-1:0];
        CFG_MAX_TIME_DELTA_US: cfg.max_time_delta_us <= cfg_wdata[MTD_W-1:0];
        default: ;
      endcase
    end
  end

  pplh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (fq_valid),
    .cmd_ready     (fq_ready),
    .cmd           (fq_cmd)
  );

  pplh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_cmd   (qb_cmd)
  );

  pplh_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (qb_valid),
    .cmd_ready     (qb_ready),
    .cmd           (qb_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### sim/landmark_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// landmark_monitor
// Watches the peak, result and register ports of the landmark hasher, keeps
// its own copy of the peak history and pair window, predicts the landmark
// transactions each accepted peak should produce, and compares every result
// transaction with the oldest prediction field by field.
// ----------------------------------------------------------------------------
module landmark_monitor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [pplh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [pplh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic [0:0]                        m_axis_tuser,
  input  logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [pplh_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pplh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                mismatch_count,
  output int                                landmarks_pending
);
  import pplh_pkg::*;

  localparam int DEPTH = HISTORY_DEPTH_DEF;

  typedef struct packed {
    logic pair_valid;
    res_t res;
    logic last;
  } landmark_t;

  landmark_t         landmark_q[$];
  logic [FREQ_W-1:0] hist_freq [DEPTH];
  logic [MAG_W-1:0]  hist_mag  [DEPTH];
  logic [TIME_W-1:0] hist_ts   [DEPTH];
  int unsigned       hist_fill;
  int unsigned       hist_wr;
  logic [FREQ_W-1:0] min_fd;
  logic [FREQ_W-1:0] max_fd;
  logic [MTD_W-1:0]  max_dt;
  int                errors = 0;

  function automatic logic [AMP_W-1:0] amplitude(input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] m;
    logic [31:0]      prod;
    m = (mag > MAG_ONE) ? MAG_ONE : mag;
    prod = 32'(m) * 32'd1000;
    return prod[25:16];
  endfunction

  // Walk the ring oldest to newest, then store the new peak.
  // A found pair is held back until the next one shows it is not the last.
  function automatic void predict_landmarks(input logic [FREQ_W-1:0] f,
                                            input logic [MAG_W-1:0] mag,
                                            input logic [TIME_W-1:0] ts);
    int unsigned       slot;
    int unsigned       k;
    logic [TIME_W-1:0] at;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] dt_ms;
    logic [FREQ_W-1:0] af;
    logic [FREQ_W-1:0] fd;
    landmark_t         lm;
    landmark_t         pend;
    logic              have_pend;
    have_pend = 1'b0;
    pend = '0;
    slot = (hist_wr + DEPTH - hist_fill) % DEPTH;
    for (k = 0; k < hist_fill; k++) begin
      at = hist_ts[slot];
      af = hist_freq[slot];
      dt = ts - at;
      dt_ms = dt / 1000;
      fd = (f >= af) ? f - af : af - f;
      if (ts >= at && dt >= MIN_AGE_US && dt <= {16'd0, max_dt} &&
          fd >= min_fd && fd <= max_fd) begin
        if (have_pend) landmark_q.insert(landmark_q.size(), pend);
        pend.pair_valid = 1'b1;
        pend.res.pair_hash = {af[HFREQ_W-1:0], f[HFREQ_W-1:0], dt_ms[DTMS_W-1:0]};
        pend.res.anchor_time_us = at;
        pend.res.anchor_frequency = af;
        pend.res.anchor_amplitude = amplitude(hist_mag[slot]);
        pend.last = 1'b0;
        have_pend = 1'b1;
      end
      slot = (slot + 1) % DEPTH;
    end
    lm = have_pend ? pend : '0;
    lm.last = 1'b1;
    landmark_q.insert(landmark_q.size(), lm);
    hist_freq[hist_wr] = f;
    hist_mag[hist_wr] = mag;
    hist_ts[hist_wr] = ts;
    hist_wr = (hist_wr + 1) % DEPTH;
    if (hist_fill < DEPTH) hist_fill++;
  endfunction

  always @(posedge clk) begin
    landmark_t want;
    landmark_t got;
    if (rst) begin
      landmark_q.delete();
      hist_fill = 0;
      hist_wr = 0;
      min_fd = MIN_FREQ_DELTA_RST;
      max_fd = MAX_FREQ_DELTA_RST;
      max_dt = MAX_TIME_DELTA_US_RST;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.pair_valid = m_axis_tuser[0];
        got.res = m_axis_tdata[96:0];
        got.last = m_axis_tlast;
        if (landmark_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t unexpected result transaction: valid=%0b hash=%h last=%0b",
                     $time, got.pair_valid, got.res.pair_hash, got.last);
        end else begin
          want = landmark_q.pop_front();
          if (got !== want || m_axis_tdata[OUT_TDATA_W-1:97] !== '0) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t landmark mismatch: exp valid=%0b hash=%h t=%h f=%0d amp=%0d last=%0b",
                       $time, want.pair_valid, want.res.pair_hash, want.res.anchor_time_us,
                       want.res.anchor_frequency, want.res.anchor_amplitude, want.last);
              $display("  got valid=%0b hash=%h t=%h f=%0d amp=%0d last=%0b pad=%h",
                       got.pair_valid, got.res.pair_hash, got.res.anchor_time_us,
                       got.res.anchor_frequency, got.res.anchor_amplitude, got.last,
                       m_axis_tdata[OUT_TDATA_W-1:97]);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MIN_FREQ_DELTA:    min_fd = cfg_wdata[FREQ_W-1:0];
          CFG_MAX_FREQ_DELTA:    max_fd = cfg_wdata[FREQ_W-1:0];
          CFG_MAX_TIME_DELTA_US: max_dt = cfg_wdata[MTD_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0]) begin
          hist_fill = 0;
          hist_wr = 0;
        end else begin
          predict_landmarks(s_axis_tdata[14:0], s_axis_tdata[31:15], s_axis_tdata[71:32]);
        end
      end
    end
    landmarks_pending <= landmark_q.size();
    mismatch_count <= errors;
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives peaks, clears and register writes into the landmark hasher with
// random gaps and output stalls: a directed pass over time, frequency and
// magnitude extremes and window edges, then random peak streams under several
// pair windows. The landmark monitor checks every result transaction.
// ----------------------------------------------------------------------------
module testbench;
  import pplh_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [TIME_W-1:0] TIME_TOP = 40'hFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0] T0 = 40'd5_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = CFG_MIN_FREQ_DELTA;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int                mismatch_count;
  int                landmarks_pending;
  int                idle_cycles = 0;
  int                stall_left = 0;
  int                calm_left = 0;
  int                calm_peaks = 0;
  int                ready_roll;
  logic [TIME_W-1:0] now_us;
  logic [FREQ_W-1:0] last_freq = '0;
  logic [FREQ_W-1:0] cur_max_fd = MAX_FREQ_DELTA_RST;
  logic [MTD_W-1:0]  cur_mtd = MAX_TIME_DELTA_US_RST;

  initial begin
    forever #5 clk = ~clk;
  end

  peak_pair_landmark_hasher i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  landmark_monitor i_monitor (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .m_axis_tlast      (m_axis_tlast),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .landmarks_pending (landmarks_pending)
  );

  // result-side backpressure: short stalls, a few long ones, calm stretches
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 2) calm_left = $urandom_range(50, 300);
        else if (ready_roll < 5) stall_left = $urandom_range(8, 40);
        else if (ready_roll < 25) stall_left = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_peak(input logic act, input logic [FREQ_W-1:0] f,
                           input logic [MAG_W-1:0] mag, input logic [TIME_W-1:0] ts);
    int gap;
    int roll;
    s_axis_tdata <= {ts, mag, f};
    s_axis_tuser <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (!act) last_freq = f;
    roll = $urandom_range(0, 99);
    if (calm_peaks > 0) begin
      calm_peaks--;
      gap = 0;
    end else if (roll < 3) begin
      calm_peaks = $urandom_range(10, 40);
      gap = 0;
    end else if (roll < 55) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(5, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off peaks until every expected landmark is out, then let the block settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (landmarks_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [FREQ_W-1:0] min_d, input logic [FREQ_W-1:0] max_d,
                            input logic [MTD_W-1:0] mtd);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_MIN_FREQ_DELTA;
    cfg_wdata <= {{(CFG_DATA_W-FREQ_W){1'b0}}, min_d};
    @(posedge clk);
    cfg_addr <= CFG_MAX_FREQ_DELTA;
    cfg_wdata <= {{(CFG_DATA_W-FREQ_W){1'b0}}, max_d};
    @(posedge clk);
    cfg_addr <= CFG_MAX_TIME_DELTA_US;
    cfg_wdata <= mtd;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_max_fd = max_d;
    cur_mtd = mtd;
  endtask

  task automatic random_peaks(input int count);
    int               roll;
    int               span;
    int               v;
    logic             act;
    logic [FREQ_W-1:0] f;
    logic [MAG_W-1:0]  mag;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      act = (roll < 4);
      if (roll >= 4 && roll < 8) begin
        now_us = now_us - TIME_W'($urandom_range(0, 400000));
      end else if (roll >= 8 && roll < 10) begin
        now_us = TIME_TOP - TIME_W'($urandom_range(0, 3000000));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 25) now_us = now_us + TIME_W'($urandom_range(0, 999));
        else if (roll < 85) now_us = now_us + TIME_W'($urandom_range(1000, 40000));
        else now_us = now_us + TIME_W'($urandom_range(0, int'(cur_mtd) + 4000));
      end
      if ($urandom_range(0, 99) < 40) begin
        f = FREQ_W'($urandom_range(0, 32767));
      end else begin
        span = int'(cur_max_fd) + 16;
        if (span > 32767) span = 32767;
        v = int'(last_freq) - span + int'($urandom_range(0, 2 * span));
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        f = v[FREQ_W-1:0];
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) mag = MAG_W'($urandom_range(0, 65536));
      else if (roll < 90) mag = MAG_W'($urandom_range(65537, 131071));
      else begin
        case ($urandom_range(0, 3))
          0: mag = '0;
          1: mag = MAG_ONE - 1'b1;
          2: mag = MAG_ONE;
          default: mag = '1;
        endcase
      end
      send_peak(act, f, mag, now_us);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset window: age limits, time running backwards, clear, top of time
    send_peak(1'b0, 15'd100, 17'd0, T0);
    send_peak(1'b0, 15'd1000, 17'd65536, T0 + 40'd999);
    send_peak(1'b0, 15'd32767, 17'd131071, T0 + 40'd1000);
    send_peak(1'b0, 15'd0, 17'd65535, T0 + 40'd5000);
    send_peak(1'b0, 15'd8191, 17'd1, T0 + 40'd2000);
    send_peak(1'b1, 15'd32767, 17'd131071, TIME_TOP);
    send_peak(1'b0, 15'd200, 17'd40000, T0 + 40'd10000);
    send_peak(1'b0, 15'd8191, 17'd65536, T0 + 40'd1_010_000);
    send_peak(1'b0, 15'd8192, 17'd100, T0 + 40'd1_010_001);
    send_peak(1'b0, 15'd12345, 17'd70000, TIME_TOP - 40'd3000);
    send_peak(1'b0, 15'd20000, 17'd65536, TIME_TOP);
    send_peak(1'b0, 15'd1, 17'd5, 40'd0);
    settle();

    // inverted frequency window
    set_window(15'd32767, 15'd0, 24'hFFFFFF);
    send_peak(1'b0, 15'd0, 17'd1, 40'd2000);
    send_peak(1'b0, 15'd32767, 17'd2, 40'd9000);
    settle();

    // single-point frequency window, time limit equal to the minimum age
    set_window(15'd100, 15'd100, 24'd1000);
    send_peak(1'b0, 15'd1000, 17'd30000, 40'd20000);
    send_peak(1'b0, 15'd1100, 17'd30000, 40'd21000);
    send_peak(1'b0, 15'd1000, 17'd30000, 40'd22000);
    send_peak(1'b0, 15'd1101, 17'd30000, 40'd23000);
    settle();

    // time limit below the minimum age: nothing pairs
    set_window(15'd0, 15'd32767, 24'd0);
    send_peak(1'b0, 15'd5, 17'd5, 40'd30000);
    send_peak(1'b0, 15'd6, 17'd6, 40'd31000);
    settle();

    now_us = 40'd100_000_000;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_window(15'd0, 15'd32767, 24'd1000000);
        1: set_window(15'd0, 15'd32767, 24'hFFFFFF);
        2: begin
          int lo;
          lo = $urandom_range(0, 200);
          set_window(FREQ_W'(lo), FREQ_W'(lo + int'($urandom_range(0, 600))),
                     MTD_W'($urandom_range(1000, 400000)));
        end
        3: set_window(FREQ_W'($urandom_range(0, 32767)), FREQ_W'($urandom_range(0, 32767)),
                      MTD_W'($urandom_range(0, 16777215)));
        4: begin
          int hi;
          hi = $urandom_range(0, 1000);
          set_window(FREQ_W'(hi + int'($urandom_range(1, 2000))), FREQ_W'(hi),
                     MTD_W'($urandom_range(1000, 2000000)));
        end
        5: set_window(15'd0, 15'd32767, MTD_W'($urandom_range(0, 2500)));
        default: set_window(15'd0, 15'd32767, 24'd1000000);
      endcase
      random_peaks(60);
      settle();
    end

    if (mismatch_count == 0 && landmarks_pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
